// ----- rtl/mspmu_pkg.sv -----
// ----------------------------------------------------------------------------
// mspmu_pkg
// Shared constants for the multi-stream minimal standard generator: the
// multiplier, the Mersenne modulus, the field widths and the item function codes.
// ----------------------------------------------------------------------------
package mspmu_pkg;

	// Minimal standard multiplier and modulus 2^31-1.
	localparam logic [14:0] MULT = 15'd16807;
	localparam logic [30:0] MODP = 31'h7FFF_FFFF;

	// Field widths of seeds and range magnitudes.
	localparam int SEED_W = 31;
	localparam int MAG_W  = 49;

	// Item function codes.
	localparam logic [1:0] FUNC_DRAW  = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

endpackage

// ----- rtl/mspmu_lcg.sv -----
// ----------------------------------------------------------------------------
// mspmu_lcg
// Bit-serial seed step: seed*16807 by shift and add over the 31 seed bits,
// then a Mersenne fold and one conditional subtract of 2^31-1.
// ----------------------------------------------------------------------------
module mspmu_lcg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] seed,
	output logic        done,
	output logic [30:0] seed_next
);

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_FOLD, ST_FIX} state_t;

	state_t      state_q;
	logic [45:0] prod_q;
	logic [4:0]  cnt_q;
	logic [31:0] fold_q;
	logic        done_q;
	logic [30:0] seed_next_q;

	logic [15:0] step_sum;
	logic [31:0] fold_sum;
	logic [31:0] modp_ext;

	// One multiplier bit per cycle: the low bit of the shift register
	// decides whether the constant joins the upper part.
	assign step_sum = {1'b0, prod_q[45:31]} +
		(prod_q[0] ? {1'b0, mspmu_pkg::MULT} : 16'd0);

	// Fold the 46-bit product: high bits weigh one modulo 2^31-1.
	assign fold_sum = {17'd0, prod_q[45:31]} + {1'b0, prod_q[30:0]};
	assign modp_ext = {1'b0, mspmu_pkg::MODP};

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prod_q      <= '0;
			cnt_q       <= '0;
			fold_q      <= '0;
			done_q      <= 1'b0;
			seed_next_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						prod_q  <= {15'd0, seed};
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= {step_sum, prod_q[30:1]};
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == 5'(mspmu_pkg::SEED_W - 1)) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					fold_q  <= fold_sum;
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					seed_next_q <= (fold_q >= modp_ext) ? 31'(fold_q - modp_ext)
						: fold_q[30:0];
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign seed_next = seed_next_q;

endmodule

// ----- rtl/mspmu_scale.sv -----
// ----------------------------------------------------------------------------
// mspmu_scale
// Computes floor(seed*mag / (2^31-1)): a bit-serial 31-step multiply into an
// 80-bit shift register, then an 80-step restoring division by the modulus.
// ----------------------------------------------------------------------------
module mspmu_scale (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] seed,
	input  logic [48:0] mag,
	output logic        done,
	output logic [48:0] offset
);

	localparam int PROD_W = mspmu_pkg::SEED_W + mspmu_pkg::MAG_W;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_OUT} state_t;

	state_t              state_q;
	logic [PROD_W-1:0]   prod_q;
	logic [48:0]         mag_q;
	logic [30:0]         rem_q;
	logic [6:0]          cnt_q;
	logic                done_q;
	logic [48:0]         offset_q;

	logic [49:0] step_sum;
	logic [31:0] trial;
	logic [31:0] trial_diff;
	logic        trial_ge;

	// Multiply step: add the magnitude into the upper part when the
	// current seed bit is set, then shift right by one.
	assign step_sum = {1'b0, prod_q[PROD_W-1:mspmu_pkg::SEED_W]} +
		(prod_q[0] ? {1'b0, mag_q} : 50'd0);

	// Division step: bring in the next dividend bit and try the modulus.
	assign trial      = {rem_q, prod_q[PROD_W-1]};
	assign trial_diff = trial - {1'b0, mspmu_pkg::MODP};
	assign trial_ge   = (trial >= {1'b0, mspmu_pkg::MODP});

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			prod_q   <= '0;
			mag_q    <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			offset_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						prod_q  <= {49'd0, seed};
						mag_q   <= mag;
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= {step_sum, prod_q[30:1]};
					cnt_q  <= cnt_q + 7'd1;
					if (cnt_q == 7'(mspmu_pkg::SEED_W - 1)) begin
						cnt_q   <= '0;
						rem_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= trial_ge ? trial_diff[30:0] : trial[30:0];
					prod_q <= {prod_q[PROD_W-2:0], trial_ge};
					cnt_q  <= cnt_q + 7'd1;
					if (cnt_q == 7'(PROD_W - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// The quotient never exceeds the magnitude.
					offset_q <= prod_q[48:0];
					done_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign offset = offset_q;

endmodule

// ----- rtl/multi_stream_park_miller_uniform.sv -----
// ----------------------------------------------------------------------------
// multi_stream_park_miller_uniform: multi-stream minimal standard uniform draws
// A draw runs the 31-step serial seed multiply, then the 31-step multiply
// plus 80-step serial division of the scaling unit.
// Load and unused items give their result the cycle after acceptance; a clear
// item and the pass after reset each step through every stream with busy high.
// ----------------------------------------------------------------------------
module multi_stream_park_miller_uniform #(
	parameter int LAST_STREAM = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         func,
	input  logic [9:0]         stream,
	input  logic signed [47:0] lower,
	input  logic signed [47:0] upper,
	input  logic [30:0]        seed_in,
	output logic               busy,
	output logic               done,
	output logic signed [47:0] value,
	output logic [31:0]        usage,
	output logic               bounds_warning
);

	localparam int DEPTH = LAST_STREAM + 1;
	localparam int AW    = (LAST_STREAM > 0) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(LAST_STREAM);

	typedef enum logic [2:0] {
		ST_SWEEP, ST_IDLE, ST_READ, ST_RANGE, ST_STEP, ST_SCALE, ST_CHECK
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       sweep_q;
	logic                sweep_init_q;
	logic [AW-1:0]       idx_q;
	logic signed [47:0]  lo_q;
	logic signed [47:0]  hi_q;
	logic [49:0]         range_q;
	logic                special_q;
	logic [48:0]         mag_q;
	logic [31:0]         usage_q;
	logic signed [49:0]  res_q;
	logic                done_q;
	logic [47:0]         value_q;
	logic [31:0]         usage_out_q;
	logic                warn_q;

	// Stream stores.
	logic [30:0] seed_mem [DEPTH];
	logic [31:0] usage_mem [DEPTH];
	logic [30:0] seed_rd_q;
	logic [31:0] usage_rd_q;

	logic          seed_we;
	logic [AW-1:0] seed_waddr;
	logic [30:0]   seed_wdata;
	logic          usage_we;
	logic [AW-1:0] usage_waddr;
	logic [31:0]   usage_wdata;

	logic [AW-1:0]      sel_idx;
	logic signed [49:0] lo_ext;
	logic signed [49:0] hi_ext;
	logic [49:0]        range_abs;
	logic [31:0]        usage_inc;

	logic        lcg_start;
	logic        lcg_done;
	logic [30:0] lcg_seed;
	logic        scale_start;
	logic        scale_done;
	logic [48:0] scale_offset;

	// A stream number beyond the last stream falls back to stream 0.
	assign sel_idx = (stream > 10'(LAST_STREAM)) ? '0 : stream[AW-1:0];

	assign lo_ext    = {{2{lo_q[47]}}, lo_q};
	assign hi_ext    = {{2{hi_q[47]}}, hi_q};
	assign range_abs = range_q[49] ? (~range_q + 50'd1) : range_q;
	assign usage_inc = (usage_q == 32'hFFFF_FFFF) ? usage_q : usage_q + 32'd1;

	assign lcg_start   = (state_q == ST_RANGE);
	assign scale_start = (state_q == ST_STEP) && lcg_done;

	// Write port selection for both stores.
	always_comb begin
		seed_we     = 1'b0;
		seed_waddr  = idx_q;
		seed_wdata  = lcg_seed;
		usage_we    = 1'b0;
		usage_waddr = idx_q;
		usage_wdata = usage_inc;
		unique case (state_q)
			ST_SWEEP: begin
				seed_we     = sweep_init_q;
				seed_waddr  = sweep_q;
				seed_wdata  = 31'd1;
				usage_we    = 1'b1;
				usage_waddr = sweep_q;
				usage_wdata = '0;
			end
			ST_IDLE: begin
				seed_we    = start && (func == mspmu_pkg::FUNC_LOAD);
				seed_waddr = sel_idx;
				seed_wdata = seed_in;
			end
			ST_STEP: begin
				seed_we  = lcg_done;
				usage_we = lcg_done;
			end
			ST_READ, ST_RANGE, ST_SCALE, ST_CHECK: begin
				seed_we  = 1'b0;
				usage_we = 1'b0;
			end
			default: begin
				seed_we  = 1'b0;
				usage_we = 1'b0;
			end
		endcase
	end

	// Store arrays: one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (seed_we) begin
			seed_mem[seed_waddr] <= seed_wdata;
		end
		seed_rd_q <= seed_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (usage_we) begin
			usage_mem[usage_waddr] <= usage_wdata;
		end
		usage_rd_q <= usage_mem[idx_q];
	end

	// Serial seed step and serial scaling unit.
	mspmu_lcg u_lcg (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (lcg_start),
		.seed      (seed_rd_q),
		.done      (lcg_done),
		.seed_next (lcg_seed)
	);

	mspmu_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_start),
		.seed   (lcg_seed),
		.mag    (mag_q),
		.done   (scale_done),
		.offset (scale_offset)
	);

	// Item sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_q      <= '0;
			sweep_init_q <= 1'b1;
			idx_q        <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			range_q      <= '0;
			special_q    <= 1'b0;
			mag_q        <= '0;
			usage_q      <= '0;
			res_q        <= '0;
			done_q       <= 1'b0;
			value_q      <= '0;
			usage_out_q  <= '0;
			warn_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_IDX) begin
						sweep_q      <= '0;
						sweep_init_q <= 1'b0;
						state_q      <= ST_IDLE;
						// A clear item reports its beat; the reset pass does not.
						if (!sweep_init_q) begin
							done_q      <= 1'b1;
							value_q     <= '0;
							usage_out_q <= '0;
							warn_q      <= 1'b0;
						end
					end
				end
				ST_IDLE: begin
					if (start) begin
						priority if (func == mspmu_pkg::FUNC_DRAW) begin
							idx_q   <= sel_idx;
							lo_q    <= lower;
							hi_q    <= upper;
							state_q <= ST_READ;
						end else if (func == mspmu_pkg::FUNC_CLEAR) begin
							sweep_q      <= '0;
							sweep_init_q <= 1'b0;
							state_q      <= ST_SWEEP;
						end else begin
							// Loads write the store at once; unused codes do nothing.
							done_q      <= 1'b1;
							value_q     <= '0;
							usage_out_q <= '0;
							warn_q      <= 1'b0;
						end
					end
				end
				ST_READ: begin
					range_q   <= 50'(hi_ext - lo_ext + 50'sd1);
					special_q <= (lo_q == 48'sd0) &&
						(hi_q == $signed({17'd0, mspmu_pkg::MODP}));
					state_q   <= ST_RANGE;
				end
				ST_RANGE: begin
					mag_q   <= special_q ? {18'd0, mspmu_pkg::MODP} : range_abs[48:0];
					usage_q <= usage_rd_q;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (lcg_done) begin
						usage_q <= usage_inc;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (scale_done) begin
						res_q   <= lo_ext + $signed({1'b0, scale_offset});
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					// The offset is never negative, so only the upper bound can fail.
					value_q     <= res_q[47:0];
					usage_out_q <= usage_q;
					warn_q      <= (res_q > hi_ext);
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign value          = $signed(value_q);
	assign usage          = usage_out_q;
	assign bounds_warning = warn_q;

endmodule
